### src/pngunf_pkg.sv
// Shared constants, types and register map of the PNG scanline unfilter.
package pngunf_pkg;

	localparam int MAX_ROW_BYTES       = 8192;
	localparam int MAX_BYTES_PER_PIXEL = 4;

	localparam int DATA_W     = 8;
	localparam int BPP_W      = 3;
	localparam int RB_W       = 14;
	localparam int POS_W      = $clog2(MAX_ROW_BYTES + 1);
	localparam int COL_W      = $clog2(MAX_ROW_BYTES);
	localparam int HIST_IDX_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register select is the word bit of paddr
	localparam logic REG_BPP = 1'b0;
	localparam logic REG_RB  = 1'b1;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	localparam logic [DATA_W-1:0] FILT_MAX = 8'd4;

	// item handed from the accept stage to the reconstruct stage
	typedef struct packed {
		logic              bad;
		logic [DATA_W-1:0] data;
		filter_t           filt;
		logic              first_row;
		logic              last;
		logic [COL_W-1:0]  col;
	} stage_item_t;

endpackage

### src/pngunf_filt_if.sv
// Stream channel carrying filtered bytes into the unfilter.
interface pngunf_filt_if;
	import pngunf_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              start_of_image;

	modport source (output valid, data_byte, start_of_image, input ready);
	modport sink (input valid, data_byte, start_of_image, output ready);
endinterface

### src/pngunf_recon_if.sv
// Stream channel carrying reconstructed bytes out of the unfilter.
interface pngunf_recon_if;
	import pngunf_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] pixel_byte;
	logic              row_end;
	logic              bad_filter;

	modport source (output valid, pixel_byte, row_end, bad_filter, input ready);
	modport sink (input valid, pixel_byte, row_end, bad_filter, output ready);
endinterface

### src/pngunf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pngunf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/png_scanline_unfilter_core.sv
// PNG scanline unfilter: rebuilds filtered image bytes, one per clock while recon is not stalled.
//
// filt carries the decompressed stream, one byte per beat; start_of_image marks
// the filter byte of the first row of a new image. recon carries one beat per
// pixel byte with row_end on the last byte of a row, or a single bad_filter
// beat when a row names a filter type above 4; after that the block drops
// bytes until the next start_of_image. Filter bytes produce no beat.
// bytes_per_pixel (addr 0) and row_bytes (addr 4) must be written over APB only
// while the stream is idle; the block itself does not enforce this.
// Throughput is one byte per cycle while recon is not stalled. The byte above
// is read from the line-store RAM (8192 x 8, registered read) in the accept
// cycle; the rebuild stage then rebuilds the byte, writes it back to the RAM
// and loads the output register.
// While recon is stalled one byte waits in the rebuild stage and one result in
// the output register; filt.ready falls until the output register drains.
// Reset clears the row position, filter, error flag and pixel histories and
// sets the first-row flag; the line store is not cleared, since every entry is
// written in a row before the next row reads it.
module png_scanline_unfilter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pngunf_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [pngunf_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pngunf_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                pready,
	pngunf_filt_if.sink                         filt,
	pngunf_recon_if.source                      recon
);
	import pngunf_pkg::*;

	function automatic logic [DATA_W-1:0] paeth(
		input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b,
		input logic [DATA_W-1:0] c
	);
		logic signed [DATA_W+2:0] da;
		logic signed [DATA_W+2:0] db;
		logic signed [DATA_W+2:0] dc;
		logic        [DATA_W+2:0] pa;
		logic        [DATA_W+2:0] pb;
		logic        [DATA_W+2:0] pc;
		logic        [DATA_W-1:0] res;
		da  = $signed({3'b000, b}) - $signed({3'b000, c});
		db  = $signed({3'b000, a}) - $signed({3'b000, c});
		dc  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
		pa  = (da < 0) ? $unsigned(-da) : $unsigned(da);
		pb  = (db < 0) ? $unsigned(-db) : $unsigned(db);
		pc  = (dc < 0) ? $unsigned(-dc) : $unsigned(dc);
		if (pa <= pb && pa <= pc) begin
			res = a;
		end else if (pb <= pc) begin
			res = b;
		end else begin
			res = c;
		end
		return res;
	endfunction

	// ---------------- configuration ----------------
	logic [BPP_W-1:0] bpp_q;
	logic [RB_W-1:0]  rb_q;
	logic             cfg_wr;
	logic [BPP_W-1:0] bpp_c;
	logic [POS_W-1:0] rb_c;
	logic [HIST_IDX_W-1:0] hsel;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= BPP_W'(1);
			rb_q  <= RB_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[APB_ADDR_W-1])
				REG_BPP: bpp_q <= pwdata[BPP_W-1:0];
				REG_RB:  rb_q  <= pwdata[RB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[APB_ADDR_W-1])
			REG_BPP: prdata = APB_DATA_W'(bpp_q);
			REG_RB:  prdata = APB_DATA_W'(rb_q);
			default: prdata = '0;
		endcase
	end

	// saturate registers into their legal ranges
	always_comb begin
		if (bpp_q == '0) begin
			bpp_c = BPP_W'(1);
		end else if (bpp_q > BPP_W'(MAX_BYTES_PER_PIXEL)) begin
			bpp_c = BPP_W'(MAX_BYTES_PER_PIXEL);
		end else begin
			bpp_c = bpp_q;
		end
		if (rb_q == '0) begin
			rb_c = POS_W'(1);
		end else if (POS_W'(rb_q) > POS_W'(MAX_ROW_BYTES)) begin
			rb_c = POS_W'(MAX_ROW_BYTES);
		end else begin
			rb_c = POS_W'(rb_q);
		end
	end

	assign hsel = HIST_IDX_W'(bpp_c - BPP_W'(1));

	// ---------------- accept stage ----------------
	logic [POS_W-1:0] pos_q;
	filter_t          filt_q;
	logic             first_q;
	logic             err_q;

	logic             accept;
	logic [POS_W-1:0] pos_eff;
	logic             first_eff;
	logic             err_eff;
	logic [POS_W-1:0] pos_m1;
	logic [POS_W-1:0] j_full;
	logic             is_last;
	logic             is_pixel;
	logic             is_bad;
	stage_item_t      item;

	logic             s1_valid_q;
	stage_item_t      item_s1;
	logic             s1_adv;
	logic             s1_fire;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_pixel_q;
	logic              out_end_q;
	logic              out_bad_q;
	logic              out_free;

	logic [DATA_W-1:0] ram_rdata;

	assign out_free   = !out_valid_q || recon.ready;
	assign s1_adv     = !s1_valid_q || out_free;
	assign s1_fire    = s1_valid_q && out_free;
	assign filt.ready = s1_adv;
	assign accept     = filt.valid && filt.ready;

	always_comb begin
		pos_eff   = filt.start_of_image ? '0 : pos_q;
		first_eff = filt.start_of_image ? 1'b1 : first_q;
		err_eff   = filt.start_of_image ? 1'b0 : err_q;
		pos_m1    = pos_eff - POS_W'(1);
		j_full    = (pos_m1 >= rb_c) ? (rb_c - POS_W'(1)) : pos_m1;
		is_last   = (j_full == rb_c - POS_W'(1));
		is_pixel  = !err_eff && (pos_eff != '0);
		is_bad    = !err_eff && (pos_eff == '0) && (filt.data_byte > FILT_MAX);

		item.bad       = is_bad;
		item.data      = filt.data_byte;
		item.filt      = filt_q;
		item.first_row = first_eff;
		item.last      = is_last;
		item.col       = j_full[COL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			filt_q  <= FILT_NONE;
			first_q <= 1'b1;
			err_q   <= 1'b0;
		end else if (accept) begin
			pos_q   <= pos_eff;
			first_q <= first_eff;
			err_q   <= err_eff;
			if (!err_eff) begin
				if (pos_eff == '0) begin
					if (filt.data_byte > FILT_MAX) begin
						err_q <= 1'b1;
					end else begin
						filt_q <= filter_t'(filt.data_byte[2:0]);
						pos_q  <= POS_W'(1);
					end
				end else if (is_last) begin
					pos_q   <= '0;
					first_q <= 1'b0;
				end else begin
					pos_q <= j_full + POS_W'(2);
				end
			end
		end
	end

	// ---------------- rebuild stage ----------------
	logic [DATA_W-1:0] left_h_q [MAX_BYTES_PER_PIXEL];
	logic [DATA_W-1:0] ul_h_q   [MAX_BYTES_PER_PIXEL];
	logic [DATA_W-1:0] a_val;
	logic [DATA_W-1:0] b_val;
	logic [DATA_W-1:0] c_val;
	logic [DATA_W:0]   ab_sum;
	logic [DATA_W-1:0] pred;
	logic [DATA_W-1:0] recon_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_q <= accept && (is_pixel || is_bad);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			item_s1 <= item;
		end
	end

	pngunf_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ROW_BYTES)
	) u_line (
		.clk   (clk),
		.we    (s1_fire && !item_s1.bad),
		.waddr (item_s1.col),
		.wdata (recon_byte),
		.re    (accept),
		.raddr (item.col),
		.rdata (ram_rdata)
	);

	always_comb begin
		a_val  = left_h_q[hsel];
		c_val  = ul_h_q[hsel];
		b_val  = item_s1.first_row ? '0 : ram_rdata;
		ab_sum = {1'b0, a_val} + {1'b0, b_val};
		unique case (item_s1.filt)
			FILT_SUB:   pred = a_val;
			FILT_UP:    pred = b_val;
			FILT_AVG:   pred = ab_sum[DATA_W:1];
			FILT_PAETH: pred = paeth(a_val, b_val, c_val);
			default:    pred = '0;
		endcase
		recon_byte = item_s1.data + pred;
	end

	// histories: start of image and row end clear, a rebuilt byte shifts in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
				left_h_q[k] <= '0;
				ul_h_q[k]   <= '0;
			end
		end else if (accept && filt.start_of_image) begin
			for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
				left_h_q[k] <= '0;
				ul_h_q[k]   <= '0;
			end
		end else if (s1_fire && !item_s1.bad) begin
			if (item_s1.last) begin
				for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
					left_h_q[k] <= '0;
					ul_h_q[k]   <= '0;
				end
			end else begin
				for (int k = MAX_BYTES_PER_PIXEL - 1; k > 0; k--) begin
					left_h_q[k] <= left_h_q[k-1];
					ul_h_q[k]   <= ul_h_q[k-1];
				end
				left_h_q[0] <= recon_byte;
				ul_h_q[0]   <= b_val;
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_pixel_q <= item_s1.bad ? '0 : recon_byte;
			out_end_q   <= !item_s1.bad && item_s1.last;
			out_bad_q   <= item_s1.bad;
		end
	end

	assign recon.valid      = out_valid_q;
	assign recon.pixel_byte = out_pixel_q;
	assign recon.row_end    = out_end_q;
	assign recon.bad_filter = out_bad_q;

	// ---------------- checks ----------------
	// a pixel read never lands on the entry being written back in the same cycle
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !item_s1.bad && accept && is_pixel |-> item_s1.col != item.col)
		else $error("line store read collides with write-back");

	// input only stalls behind a blocked output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!filt.ready |-> out_valid_q && !recon.ready && s1_valid_q)
		else $error("input stalled without output back-pressure");

	// a bad filter byte latches the error and leaves the row position at zero
	a_err_latch: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_bad |=> err_q && pos_q == '0)
		else $error("bad filter did not set error");

	// the last byte of a row returns the row position to the filter byte
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_pixel && is_last |=> pos_q == '0 && !first_q)
		else $error("row end did not reset position");

	// an error beat never carries pixel data or a row end
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_bad_q |-> out_pixel_q == '0 && !out_end_q)
		else $error("error beat carries data");

endmodule
